### rtl/tpdb_pkg.sv
// Shared types and constants for the three-phase density blend core.
// No dependencies.
`default_nettype none
package tpdb_pkg;

  // Register indexes on the configuration port (byte address 4*index).
  localparam logic [1:0] REG_FLUID = 2'd0;
  localparam logic [1:0] REG_GAS   = 2'd1;
  localparam logic [1:0] REG_SOLID = 2'd2;
  localparam logic [1:0] REG_CELLS = 2'd3;

  // How the gas weight is chosen.
  typedef logic [1:0] hsel_t;
  localparam hsel_t H_ZERO = 2'd0;
  localparam hsel_t H_ONE  = 2'd1;
  localparam hsel_t H_HALF = 2'd2;
  localparam hsel_t H_BAND = 2'd3;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // Quotient bits of ap * 2^16 / beta.
  localparam int QBITS = 17;

endpackage
`default_nettype wire

### rtl/three_phase_density_blend_core.sv
// Three-phase density blend: side-point density from liquid, gas and solid phases.
// Depends on tpdb_pkg.
`default_nettype none
// Usage:
//   Input channel (in_valid/in_ready) carries one grid side point per word:
//   solid level, lower and upper gas level set (signed Q8.24) and grid
//   spacing (unsigned Q7.24). Output channel (out_valid/out_ready) returns
//   one density word (unsigned Q16.16) per input word, in order.
//   Configuration is an APB-style port (psel, penable, pwrite, paddr, pwdata,
//   prdata, pready), registers at 0x0 fluid, 0x4 gas, 0x8 solid density and
//   0xC interface cells (Q8.8). pready is always high; write only while idle.
//   Throughput: one word per cycle while the receiver does not stall.
//   Pipeline: 24 register stages, made up of the 17-stage restoring divider
//   that forms phi/beta one quotient bit per stage, plus input, classify,
//   round, table, weight, multiply and output stages.
//   SINE_TABLE_ENTRIES must be a power of two (64..16384); the sine table is
//   a constant ROM with a registered read.
//   Reset (rst_n low, synchronous) drops all words in flight and loads the
//   register defaults. When the receiver stalls with a word waiting, every
//   stage holds, bubbles included, and in_ready drops in the same cycle;
//   nothing is dropped or repeated.
module three_phase_density_blend_core #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] in_solid_level,
  input  wire  [31:0] in_gas_level_lower,
  input  wire  [31:0] in_gas_level_upper,
  input  wire  [30:0] in_grid_spacing,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_density,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tpdb_pkg::*;

  localparam int N    = SINE_TABLE_ENTRIES;
  localparam int LOG  = $clog2(N);
  localparam int SH   = 15 - LOG;
  localparam int NST  = 24;
  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210};

  // sin(pi k/N)/(2 pi) in Q0.16; evaluated at elaboration only.
  function automatic logic [15:0] rom_val(input int unsigned kk);
    longint unsigned r, a, a2, term, sum, s, v;
    r = (kk <= N - kk) ? longint'(kk) : longint'(N - kk);
    a = (PI_Q30 * r + longint'(N / 2)) / N;
    a2 = (a * a + (64'd1 << 29)) >> 30;
    term = a;
    sum = a;
    for (int n = 0; n < 7; n++) begin
      term = ((term * a2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 0) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    s = sum;
    v = (s * 64'd65536 + TWO_PI_Q30 / 2) / TWO_PI_Q30;
    return v[15:0];
  endfunction

  logic [15:0] rom_w [N];
  for (genvar g = 0; g < N; g++) begin : g_rom
    assign rom_w[g] = rom_val(g);
  end

  // ---------------- configuration registers ----------------
  logic [31:0] fluid_r, gas_r, solid_r;
  logic [15:0] cells_r;
  logic        wr_w;

  assign pready = 1'b1;
  assign wr_w   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fluid_r <= 32'd65536000;
      gas_r   <= 32'd78643;
      solid_r <= 32'd65536000;
      cells_r <= 16'd512;
    end else if (wr_w) begin
      unique case (paddr[3:2])
        REG_FLUID: fluid_r <= pwdata;
        REG_GAS:   gas_r   <= pwdata;
        REG_SOLID: solid_r <= pwdata;
        REG_CELLS: cells_r <= pwdata[15:0];
        default:   fluid_r <= fluid_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FLUID: prdata = fluid_r;
      REG_GAS:   prdata = gas_r;
      REG_SOLID: prdata = solid_r;
      REG_CELLS: prdata = {16'd0, cells_r};
      default:   prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // Advance every stage together; hold all when the output word is stalled.
  logic [NST-1:0] v_r;
  logic           adv_w;

  assign adv_w     = ~v_r[NST-1] | out_ready;
  assign in_ready  = adv_w;
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv_w) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // Stage 0: sum the gas levels, form beta = cells * spacing.
  logic signed [32:0] sum_r0;
  logic [46:0]        b_r0;
  logic               sp_r0;

  always_ff @(posedge clk) begin
    if (adv_w) begin
      sum_r0 <= $signed({in_gas_level_lower[31], in_gas_level_lower})
              + $signed({in_gas_level_upper[31], in_gas_level_upper});
      b_r0   <= 47'(cells_r) * 47'(in_grid_spacing);
      sp_r0  <= ~in_solid_level[31] & (in_solid_level[30:0] != 31'd0);
    end
  end

  // Stage 1: classify phi against +-beta, take |phi|.
  logic signed [48:0] p_w, bs_w;
  logic [39:0]        ap_w;
  hsel_t              cls_w;
  logic [39:0]        ap_r1;
  logic [46:0]        b_r1;
  hsel_t              cls_r1;
  logic               neg_r1, sp_r1;

  always_comb begin
    p_w  = 49'(sum_r0) <<< 7;
    bs_w = $signed({2'b00, b_r0});
    ap_w = sum_r0[32] ? 40'(-p_w) : 40'(p_w);
    if (b_r0 == 47'd0) begin
      if (sum_r0 < 0) cls_w = H_ZERO;
      else if (sum_r0 > 0) cls_w = H_ONE;
      else cls_w = H_HALF;
    end else if (p_w < -bs_w) begin
      cls_w = H_ZERO;
    end else if (p_w > bs_w) begin
      cls_w = H_ONE;
    end else begin
      cls_w = H_BAND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_w) begin
      ap_r1  <= ap_w;
      b_r1   <= (b_r0 == 47'd0) ? 47'd1 : b_r0;
      cls_r1 <= cls_w;
      neg_r1 <= sum_r0[32];
      sp_r1  <= sp_r0;
    end
  end

  // Stages 2..18: restoring divider, one quotient bit of ap*2^16/beta each.
  logic [47:0]       dr_r   [QBITS];
  logic [QBITS-1:0]  dq_r   [QBITS];
  logic [46:0]       db_r   [QBITS];
  hsel_t             dcls_r [QBITS];
  logic              dneg_r [QBITS];
  logic              dsp_r  [QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    logic [47:0]      rin_w;
    logic [46:0]      bin_w;
    logic [QBITS-1:0] qin_w;
    hsel_t            cin_w;
    logic             nin_w, sin_w, ge_w;
    if (j == 0) begin : g_first
      assign rin_w = {8'd0, ap_r1};
      assign bin_w = b_r1;
      assign qin_w = '0;
      assign cin_w = cls_r1;
      assign nin_w = neg_r1;
      assign sin_w = sp_r1;
    end else begin : g_next
      assign rin_w = {dr_r[j-1][46:0], 1'b0};
      assign bin_w = db_r[j-1];
      assign qin_w = dq_r[j-1];
      assign cin_w = dcls_r[j-1];
      assign nin_w = dneg_r[j-1];
      assign sin_w = dsp_r[j-1];
    end
    assign ge_w = rin_w >= {1'b0, bin_w};
    always_ff @(posedge clk) begin
      if (adv_w) begin
        dr_r[j]   <= ge_w ? rin_w - {1'b0, bin_w} : rin_w;
        dq_r[j]   <= {qin_w[QBITS-2:0], ge_w};
        db_r[j]   <= bin_w;
        dcls_r[j] <= cin_w;
        dneg_r[j] <= nin_w;
        dsp_r[j]  <= sin_w;
      end
    end
  end

  // Stage 19: round to the half term and the table index.
  logic [17:0] th_w, tk_w;
  logic [16:0] half_r19;
  logic [LOG:0] k_r19;
  hsel_t       cls_r19;
  logic        neg_r19, sp_r19;

  assign th_w = {1'b0, dq_r[QBITS-1]} + 18'd1;
  assign tk_w = ({1'b0, dq_r[QBITS-1]} >> SH) + 18'd1;

  always_ff @(posedge clk) begin
    if (adv_w) begin
      half_r19 <= th_w[17:1];
      k_r19    <= tk_w[LOG+1:1];
      cls_r19  <= dcls_r[QBITS-1];
      neg_r19  <= dneg_r[QBITS-1];
      sp_r19   <= dsp_r[QBITS-1];
    end
  end

  // Stage 20: sine table read; index N gives zero.
  logic [15:0] st_r20;
  logic [16:0] half_r20;
  hsel_t       cls_r20;
  logic        neg_r20, sp_r20;

  always_ff @(posedge clk) begin
    if (adv_w) begin
      st_r20   <= k_r19[LOG] ? 16'd0 : rom_w[k_r19[LOG-1:0]];
      half_r20 <= half_r19;
      cls_r20  <= cls_r19;
      neg_r20  <= neg_r19;
      sp_r20   <= sp_r19;
    end
  end

  // Stage 21: gas weight, saturated to [0, 1].
  logic signed [18:0] hs_w;
  logic [16:0]        h_w, h_r21;
  logic               sp_r21;

  always_comb begin
    if (neg_r20) begin
      hs_w = $signed({2'b0, HALF_Q16}) - $signed({2'b0, half_r20})
           - $signed({3'b0, st_r20});
    end else begin
      hs_w = $signed({2'b0, HALF_Q16}) + $signed({2'b0, half_r20})
           + $signed({3'b0, st_r20});
    end
    case (cls_r20)
      H_ZERO: h_w = 17'd0;
      H_ONE:  h_w = ONE_Q16;
      H_HALF: h_w = HALF_Q16;
      default: begin
        if (hs_w < 0) h_w = 17'd0;
        else if (hs_w > $signed({2'b0, ONE_Q16})) h_w = ONE_Q16;
        else h_w = hs_w[16:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_w) begin
      h_r21  <= h_w;
      sp_r21 <= sp_r20;
    end
  end

  // Stage 22: both blend products.
  logic [48:0] pg_r22, pf_r22;
  logic        sp_r22;

  always_ff @(posedge clk) begin
    if (adv_w) begin
      pg_r22 <= 49'(gas_r) * 49'(ONE_Q16 - h_r21);
      pf_r22 <= 49'(fluid_r) * 49'(h_r21);
      sp_r22 <= sp_r21;
    end
  end

  // Stage 23: round, select solid, output word register.
  logic [49:0] acc_w;
  logic [31:0] dens_r;

  assign acc_w = 50'(pg_r22) + 50'(pf_r22) + 50'd32768;

  always_ff @(posedge clk) begin
    if (adv_w) begin
      dens_r <= sp_r22 ? solid_r : acc_w[47:16];
    end
  end

  assign out_density = dens_r;

endmodule
`default_nettype wire

### verif/three_phase_density_blend_core_tb.sv
// Self-checking bench for three_phase_density_blend_core: streams side points,
// writes the four density/width registers between phases, checks every density word.
// Depends on tpdb_pkg and the core RTL.
`default_nettype none
module three_phase_density_blend_core_tb;
  import tpdb_pkg::*;

  localparam int N_SINE      = 1024;
  localparam int DRAIN_WAIT  = 40;      // a bit over the 24-stage pipeline
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 290;

  typedef struct packed {
    logic [31:0] solid;
    logic [31:0] lower;
    logic [31:0] upper;
    logic [30:0] spacing;
  } side_point_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_solid_level;
  logic [31:0] in_gas_level_lower;
  logic [31:0] in_gas_level_upper;
  logic [30:0] in_grid_spacing;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_density;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  three_phase_density_blend_core #(.SINE_TABLE_ENTRIES(N_SINE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_solid_level(in_solid_level), .in_gas_level_lower(in_gas_level_lower),
    .in_gas_level_upper(in_gas_level_upper), .in_grid_spacing(in_grid_spacing),
    .out_valid(out_valid), .out_ready(out_ready), .out_density(out_density),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Register shadow copies, updated as each write lands.
  logic [31:0] fluid_rho;
  logic [31:0] gas_rho;
  logic [31:0] solid_rho;
  logic [15:0] iface_cells;

  longint unsigned sine_lut [N_SINE];
  side_point_t     point_queue[$];   // words waiting for the driver
  logic [31:0]     density_queue[$]; // densities owed by the core
  int              fail_count;
  int              words_out;
  int              cycle_count;
  bit              idle_on;          // random gaps on the sender side
  int              send_gap;
  int              recv_gap;
  int              long_hold;
  bit              long_hold_done;

  // ---------------------------------------------------------------- predictor
  // sin(a) for 0 <= a <= pi/2, both unsigned Q2.30, by truncated Taylor series.
  function automatic longint unsigned sine_q30(longint unsigned a);
    longint unsigned a2, term, sum;
    a2 = (a * a + (64'd1 << 29)) >> 30;
    term = a;
    sum = a;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = (term > sum) ? 0 : sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // Smoothed Heaviside weight in Q1.16, saturated to [0, 1].
  function automatic int gas_fraction(longint p, longint unsigned b);
    longint unsigned ap, half, k, sterm;
    int h;
    if (b == 0) return (p < 0) ? 0 : (p > 0) ? int'(ONE_Q16) : int'(HALF_Q16);
    if (p < -longint'(b)) return 0;
    if (p > longint'(b)) return int'(ONE_Q16);
    ap = (p < 0) ? longint'(-p) : p;
    half = (ap * 65536 + b) / (2 * b);
    k = (ap * 2 * N_SINE + b) / (2 * b);
    sterm = (k < N_SINE) ? sine_lut[k] : 0;
    if (p < 0) h = 32768 - int'(half) - int'(sterm);
    else h = 32768 + int'(half) + int'(sterm);
    if (h < 0) h = 0;
    if (h > int'(ONE_Q16)) h = int'(ONE_Q16);
    return h;
  endfunction

  function automatic logic [31:0] blended_density(side_point_t sp);
    longint p;
    longint unsigned b, h, rho;
    if ($signed(sp.solid) > 0) return solid_rho;
    p = (longint'($signed(sp.lower)) + longint'($signed(sp.upper))) * 128;
    b = longint'(iface_cells) * longint'(sp.spacing);
    h = gas_fraction(p, b);
    rho = (longint'(gas_rho) * (65536 - h) + longint'(fluid_rho) * h + 32768) >> 16;
    return rho[31:0];
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic side_point_t make_point(logic [31:0] sol, longint s, longint jit,
                                             logic [30:0] sp);
    side_point_t pt;
    longint lo, up;
    lo = s >>> 1;
    up = s - lo;
    // Spread the sum across both cells when it stays in range.
    if (lo + jit <= 64'sd2147483647 && lo + jit >= -64'sd2147483648 &&
        up - jit <= 64'sd2147483647 && up - jit >= -64'sd2147483648) begin
      lo = lo + jit;
      up = up - jit;
    end
    pt.solid = sol;
    pt.lower = lo[31:0];
    pt.upper = up[31:0];
    pt.spacing = sp;
    return pt;
  endfunction

  function automatic side_point_t random_point();
    side_point_t pt;
    logic [31:0] sol;
    logic [30:0] sp;
    longint unsigned b, lim;
    longint s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) sol = $urandom_range(1, 32'h7fffffff);
    else if (r < 30) sol = 32'd0;
    else sol = 32'h80000000 | $urandom;
    sp = 31'($urandom & ((32'd1 << $urandom_range(1, 31)) - 1));
    if (sp == 0) sp = 31'd1;
    if ($urandom_range(0, 99) < 30) begin
      pt.solid = sol;
      pt.lower = $urandom;
      pt.upper = $urandom;
      pt.spacing = sp;
      return pt;
    end
    // Aim phi at the smooth band, edges included.
    b = longint'(iface_cells) * longint'(sp);
    lim = (b >> 7) + 4;
    if (lim > 64'd2147483647) lim = 64'd2147483647;
    s = longint'({$urandom, $urandom} % (2 * lim + 1)) - longint'(lim);
    return make_point(sol, s, longint'($urandom_range(0, 1000)) - 500, sp);
  endfunction

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) point_queue.push_back(random_point());
  endtask

  // Edge cases at reset config (cells = 2.0): spacing 1 gives beta = 512 = 4*128.
  task automatic queue_directed();
    point_queue.push_back(make_point(32'h7fffffff, 0, 0, 31'd1));
    point_queue.push_back(make_point(32'd1, 0, 0, 31'd1));
    point_queue.push_back(make_point(32'd0, 0, 0, 31'd1));
    point_queue.push_back(make_point(32'h80000000, 0, 0, 31'd1));
    point_queue.push_back(make_point(32'hffffffff, 4, 0, 31'd1));
    point_queue.push_back(make_point(32'hffffffff, 5, 0, 31'd1));
    point_queue.push_back(make_point(32'hffffffff, -4, 0, 31'd1));
    point_queue.push_back(make_point(32'hffffffff, -5, 0, 31'd1));
    point_queue.push_back(make_point(32'hffffffff, 3, 0, 31'd1));
    point_queue.push_back(make_point(32'hffffffff, -3, 0, 31'd1));
    point_queue.push_back(make_point(32'd0, 1, 0, 31'd1));
    point_queue.push_back(make_point(32'd0, 64'sd67108864, 0, 31'h01000000));
    point_queue.push_back(make_point(32'd0, 64'sd67108863, 0, 31'h01000000));
    point_queue.push_back(make_point(32'd0, -64'sd67108863, 7, 31'h01000000));
    point_queue.push_back(make_point(32'd0, -64'sd67108865, 0, 31'h01000000));
    point_queue.push_back(make_point(32'd0, 64'sd4294967294, 0, 31'h7fffffff));
    point_queue.push_back(make_point(32'd0, -64'sd4294967296, 0, 31'h7fffffff));
    point_queue.push_back(make_point(32'd0, 64'sd4294967294, 0, 31'd1));
    point_queue.push_back(make_point(32'd0, -64'sd4294967296, 0, 31'd1));
    point_queue.push_back(make_point(32'd0, -1, 0, 31'h7fffffff));
    point_queue.push_back(make_point(32'h80000000, 64'sd2147483647, 1, 31'h55555555));
    point_queue.push_back(make_point(32'h00000000, 0, 0, 31'h2aaaaaaa));
  endtask

  // ------------------------------------------------------------- config port
  // Setup cycle, then access cycle; the register lands on the access edge.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FLUID: fluid_rho = val;
      REG_GAS:   gas_rho = val;
      REG_SOLID: solid_rho = val;
      REG_CELLS: iface_cells = val[15:0];
    endcase
  endtask

  task automatic set_densities(logic [31:0] f, logic [31:0] g, logic [31:0] s,
                               logic [15:0] c);
    write_reg(REG_FLUID, f);
    write_reg(REG_GAS, g);
    write_reg(REG_SOLID, s);
    write_reg(REG_CELLS, {16'd0, c});
  endtask

  // Hold until every owed density is back, then let the pipe empty out.
  task automatic wait_drained();
    while (point_queue.size() != 0 || in_valid || density_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // --------------------------------------------------------------- clock/reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Main sequence: build the sine table, reset, then run config phases.
  initial begin
    longint unsigned r, a;
    for (int k = 0; k < N_SINE; k++) begin
      r = (k <= N_SINE - k) ? k : N_SINE - k;
      a = (64'd3373259426 * r + N_SINE / 2) / N_SINE;
      sine_lut[k] = (sine_q30(a) * 65536 + 64'd6746518852 / 2) / 64'd6746518852;
    end
    fluid_rho = 32'd65536000;
    gas_rho = 32'd78643;
    solid_rho = 32'd65536000;
    iface_cells = 16'd512;
    fail_count = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: edges first, then random words.
    queue_directed();
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Extremes: zero fluid, full-scale gas, narrowest band.
    set_densities(32'd0, 32'hffffffff, 32'hffffffff, 16'd1);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Opposite extremes, sender runs without gaps.
    idle_on = 1'b0;
    set_densities(32'hffffffff, 32'd0, 32'd0, 16'hffff);
    queue_random(PHASE_ITEMS);
    wait_drained();
    idle_on = 1'b1;

    set_densities($urandom, $urandom, $urandom, 16'h0100);
    queue_random(PHASE_ITEMS);
    wait_drained();

    set_densities($urandom, $urandom, $urandom,
                  16'h8000 | 16'($urandom_range(0, 16'h7fff)));
    queue_random(PHASE_ITEMS);
    wait_drained();

    set_densities($urandom, $urandom, $urandom, 16'($urandom_range(1, 65535)));
    queue_random(PHASE_ITEMS);
    wait_drained();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver
  // Hold the word until taken; insert random gaps between words.
  always @(posedge clk) begin
    side_point_t nxt;
    int r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_solid_level <= '0;
      in_gas_level_lower <= '0;
      in_gas_level_upper <= '0;
      in_grid_spacing <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        density_queue.push_back(blended_density({in_solid_level, in_gas_level_lower,
                                                 in_gas_level_upper, in_grid_spacing}));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (point_queue.size() != 0) begin
          nxt = point_queue.pop_front();
          in_valid <= 1'b1;
          in_solid_level <= nxt.solid;
          in_gas_level_lower <= nxt.lower;
          in_gas_level_upper <= nxt.upper;
          in_grid_spacing <= nxt.spacing;
          r = $urandom_range(0, 99);
          if (!idle_on || r < 60) send_gap <= 0;
          else if (r < 94) send_gap <= $urandom_range(1, 3);
          else send_gap <= $urandom_range(10, 40);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  // Compare each density word with the oldest prediction; stall at random,
  // and once hold off long enough to back the pipe up into the input.
  always @(posedge clk) begin
    logic [31:0] want;
    int r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      long_hold <= 0;
      long_hold_done <= 1'b0;
      words_out <= 0;
    end else begin
      if (out_valid && out_ready) begin
        words_out <= words_out + 1;
        if (density_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: density word 0x%08h with none expected", $time, out_density);
        end else begin
          want = density_queue.pop_front();
          if (out_density !== want) begin
            fail_count <= fail_count + 1;
            $display("%0t: density mismatch: expected 0x%08h, actual 0x%08h",
                     $time, want, out_density);
          end
        end
      end
      if (!long_hold_done && words_out == 400) begin
        long_hold_done <= 1'b1;
        long_hold <= 300;
        out_ready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ready <= (long_hold == 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= (recv_gap == 1);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          recv_gap <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
        end
      end
    end
  end

  // ----------------------------------------------------------------- timeout
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

### files.f
rtl/tpdb_pkg.sv
rtl/three_phase_density_blend_core.sv
verif/three_phase_density_blend_core_tb.sv
